FILE: rtl/sctp_chk_pkg.sv
// ----------------------------------------------------------------------------
// SCTP checksum check package
// Shared constants, status codes and the byte-wide CRC32c update.
// ----------------------------------------------------------------------------
package sctp_chk_pkg;

    localparam logic [31:0] CRC32C_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT   = 32'hFFFF_FFFF;
    localparam int          HDR_BYTES    = 12;
    localparam int          POS_W        = 4;
    localparam logic [POS_W-1:0] POS_TAG_LO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TAG_HI = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(8);
    localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(11);
    localparam logic [POS_W-1:0] POS_FULL   = POS_W'(HDR_BYTES);

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_CRC_ERR   = 2'd2,
        ST_TAG_ERR   = 2'd3
    } t_status;

    // Reflected CRC32c, one byte, bit-serial form unrolled over eight steps.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC32C_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sctp_chk_if.sv
// ----------------------------------------------------------------------------
// SCTP checksum check channels
// Valid/ready channels for packet byte beats and status beats.
// ----------------------------------------------------------------------------
interface sctp_chk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source(output valid, output data_byte, output last, input ready);
    modport sink(input valid, input data_byte, input last, output ready);
endinterface

interface sctp_chk_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] stored_checksum;
    logic [31:0] computed_checksum;
    logic [31:0] packet_tag;

    modport source(output valid, output status, output stored_checksum,
                   output computed_checksum, output packet_tag, input ready);
    modport sink(input valid, input status, input stored_checksum,
                 input computed_checksum, input packet_tag, output ready);
endinterface

FILE: rtl/sctp_packet_checksum_tag_check.sv
// ----------------------------------------------------------------------------
// SCTP packet checksum and verification tag check
// Runs CRC32c over a received SCTP packet and checks length, checksum and tag.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries the packet one byte per beat in wire order; last marks the
//   final byte. Bytes 4..7 are taken as the verification tag (big-endian),
//   bytes 8..11 as the stored checksum (little-endian, fed to the CRC as 0).
//   o_out carries one status beat per packet, issued for the last byte.
//   i_cfg_we/i_cfg_data load the expected tag (0 disables the tag check);
//   write it only between packets.
//   Throughput: one byte per cycle unless stalled. The byte-wide CRC update and
//   the final compares sit between the running state and the output register.
//   Latency: the status beat is valid the cycle after the last byte is taken.
//   Reset: CRC, captures and byte count restart, expected tag clears, no
//   status beat is pending.
//   Stall: the output register holds its beat while o_out.ready is low; input
//   beats keep flowing until a new status beat would be needed, then i_in
//   stalls until the pending beat is taken.
// ----------------------------------------------------------------------------
module sctp_packet_checksum_tag_check
    import sctp_chk_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sctp_chk_in_if.sink            i_in,
    sctp_chk_out_if.source         o_out,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_data
);

    logic [31:0]      r_exp_tag;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_chk, n_chk;
    logic [31:0]      r_tag, n_tag;
    logic [POS_W-1:0] r_pos, n_pos;

    logic             r_out_valid;
    t_status          r_status, n_status;
    logic [31:0]      r_out_chk, r_out_crc, r_out_tag;
    logic [31:0]      computed;

    logic             in_fire;
    logic             out_free;
    logic             in_chk;
    logic             in_tag;
    logic [7:0]       crc_feed;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = out_free || !i_in.last;
    assign in_fire    = i_in.valid && i_in.ready;

    assign in_chk   = (r_pos >= POS_CHK_LO) && (r_pos <= POS_CHK_HI);
    assign in_tag   = (r_pos >= POS_TAG_LO) && (r_pos <= POS_TAG_HI);
    assign crc_feed = in_chk ? 8'd0 : i_in.data_byte;

    always_comb begin
        n_crc = crc32c_byte(r_crc, crc_feed);
        n_chk = r_chk;
        n_tag = r_tag;
        n_pos = r_pos;
        if (in_chk) begin
            n_chk[8*r_pos[1:0] +: 8] = i_in.data_byte;
        end
        if (in_tag) begin
            n_tag = {r_tag[23:0], i_in.data_byte};
        end
        if (r_pos < POS_FULL) begin
            n_pos = r_pos + POS_W'(1);
        end
        computed = n_crc ^ CRC_XOROUT;
        if (n_pos < POS_FULL) begin
            n_status = ST_TOO_SHORT;
        end else if (n_chk != computed) begin
            n_status = ST_CRC_ERR;
        end else if (n_tag != 32'd0 && r_exp_tag != 32'd0 && n_tag != r_exp_tag) begin
            n_status = ST_TAG_ERR;
        end else begin
            n_status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_tag   <= 32'd0;
            r_crc       <= CRC_INIT;
            r_chk       <= 32'd0;
            r_tag       <= 32'd0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_tag <= i_cfg_data;
            end
            if (in_fire && i_in.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                if (i_in.last) begin
                    r_crc       <= CRC_INIT;
                    r_chk       <= 32'd0;
                    r_tag       <= 32'd0;
                    r_pos       <= '0;
                end else begin
                    r_crc <= n_crc;
                    r_chk <= n_chk;
                    r_tag <= n_tag;
                    r_pos <= n_pos;
                end
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.last) begin
            r_status <= n_status;
            if (n_pos < POS_FULL) begin
                r_out_chk <= 32'd0;
                r_out_crc <= 32'd0;
                r_out_tag <= 32'd0;
            end else begin
                r_out_chk <= n_chk;
                r_out_crc <= computed;
                r_out_tag <= n_tag;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_status;
    assign o_out.stored_checksum   = r_out_chk;
    assign o_out.computed_checksum = r_out_crc;
    assign o_out.packet_tag        = r_out_tag;

endmodule
